[hdl/edc_pkg.sv]
package edc_pkg;

  localparam int CW = 22;

  localparam logic ACT_TO_DATE  = 1'b0;
  localparam logic ACT_TO_COUNT = 1'b1;

  localparam logic [CW-1:0] LAST_INDEX = 22'd2932896;
  localparam logic [CW-1:0] EPOCH_DAYS = 22'd719162;
  localparam logic [CW-1:0] EPOCH_NEG  = 22'd3475142;  // 2^22 - EPOCH_DAYS
  localparam logic [13:0]   YEAR_MIN   = 14'd1970;
  localparam logic [13:0]   YEAR_MAX   = 14'd9999;

  localparam logic [CW-1:0] DAYS_400 = 22'd146097;
  localparam logic [CW-1:0] DAYS_100 = 22'd36524;
  localparam logic [CW-1:0] DAYS_4   = 22'd1461;
  localparam logic [CW-1:0] DAYS_1   = 22'd365;
  localparam logic [CW-1:0] YRS_400  = 22'd400;
  localparam logic [CW-1:0] YRS_100  = 22'd100;
  localparam logic [CW-1:0] YRS_4    = 22'd4;
  localparam logic [CW-1:0] YRS_1    = 22'd1;
  localparam logic [CW-1:0] WEEK     = 22'd7;

  localparam logic [4:0] WDAY_TOP = 5'd19;
  localparam logic [4:0] Y400_TOP = 5'd4;
  localparam logic [4:0] Y100_TOP = 5'd1;
  localparam logic [4:0] Y4_TOP   = 5'd4;
  localparam logic [4:0] Y1_TOP   = 5'd1;

  localparam logic [2:0] WD_OFS_DAYS  = 3'd1;  // 0001-01-01 is a Monday
  localparam logic [2:0] WD_OFS_EPOCH = 3'd4;  // 1970-01-01 is a Thursday

  typedef struct packed {
    logic        action;
    logic [21:0] day_count;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } edc_req_t;

  typedef struct packed {
    logic [21:0] out_day_count;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [2:0]  weekday;
    logic        valid_res;
    logic        date_error;
  } edc_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WDAY,
    ST_Y400,
    ST_Y100,
    ST_Y4,
    ST_Y1,
    ST_MONTH,
    ST_DAYS
  } edc_state_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  function automatic logic [2:0] wday_fix(input logic [2:0] r, input logic [2:0] ofs);
    logic [3:0] s;
    s = {1'b0, r} + {1'b0, ofs};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

endpackage

[hdl/edc_step.sv]
module edc_step
  import edc_pkg::*;
(
  input  logic [CW-1:0] a,
  input  logic [CW-1:0] b,
  input  logic [CW-1:0] c,
  input  logic [CW-1:0] q,
  output logic          ge,
  output logic [CW-1:0] a_out,
  output logic [CW-1:0] c_out
);

  logic [CW:0] diff;

  // conditional subtract on a, matching accumulate on c
  assign diff  = {1'b0, a} - {1'b0, b};
  assign ge    = !diff[CW];
  assign a_out = ge ? diff[CW-1:0] : a;
  assign c_out = ge ? (c + q) : c;

endmodule

[hdl/epoch_day_date_converter.sv]
// Day count / calendar date converter, Gregorian 4/100/400 rules.
// Request channel: req is taken at a rising edge with start high and busy
// low. action 0 turns day_count (days since 1970-01-01) into a date and a
// weekday (Sunday 0); action 1 checks day/month/year and gives the count.
// Result channel: rsp is valid for exactly one cycle with done high; the
// receiver must take it then, there is no stall. busy is high while a
// transaction is in flight.
// Sequence: one compare-subtract-accumulate unit is stepped by the sequencer.
//   action 0: the mod 7 weekday steps, the steps through the 400, 100, 4
//   and 1 year blocks, then the month steps, with the
//   result in the next cycle.
//   action 1: the year steps, the month/day add, then the weekday steps,
//   result in the next cycle. A day of 0 or past the end of its month is
//   caught at the month/day add. A count past range or a bad month or year
//   finishes without leaving idle, busy stays low, result in the next cycle.
// One transaction is in flight at a time; a new start is taken in the
// cycle done is high.
// Reset (rst, synchronous) returns to idle and drops done.
module epoch_day_date_converter
  import edc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  edc_req_t req,
  output logic     busy,
  output logic     done,
  output edc_rsp_t rsp
);

  edc_state_t    state, state_next;
  logic [4:0]    k, k_next;
  logic [CW-1:0] a, a_next;
  logic [CW-1:0] c, c_next;
  logic [1:0]    n100, n100_next;
  logic [4:0]    n4, n4_next;
  logic [1:0]    n1, n1_next;
  logic [2:0]    wd, wd_next;
  logic [3:0]    mm, mm_next;
  edc_req_t      req_q, req_q_next;
  edc_rsp_t      rsp_q, rsp_q_next;
  logic          done_q, done_next;

  logic [CW-1:0] op_b, op_q;
  logic          u_ge;
  logic [CW-1:0] u_a, u_c;
  logic          leap;
  logic [9:0]    mo_off;
  logic          to_date;

  edc_step u_step (
    .a     (a),
    .b     (op_b),
    .c     (c),
    .q     (op_q),
    .ge    (u_ge),
    .a_out (u_a),
    .c_out (u_c)
  );

  // leap from the year-1 digits: last of a 4-block, not a century end unless 400
  assign leap    = (n1 == 2'd3) && ((n4 != 5'd24) || (n100 == 2'd3));
  assign to_date = (req_q.action == ACT_TO_DATE);
  assign mo_off  = {1'b0, days_before(req_q.month, leap)} + {5'd0, req_q.day} - 10'd1;

  always_comb begin
    state_next = state;
    k_next     = k;
    a_next     = a;
    c_next     = c;
    n100_next  = n100;
    n4_next    = n4;
    n1_next    = n1;
    wd_next    = wd;
    mm_next    = mm;
    req_q_next = req_q;
    rsp_q_next = rsp_q;
    done_next  = 1'b0;
    op_b       = '0;
    op_q       = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          req_q_next = req;
          n100_next  = '0;
          n4_next    = '0;
          n1_next    = '0;
          if (req.action == ACT_TO_DATE) begin
            if (req.day_count > LAST_INDEX) begin
              rsp_q_next = '0;
              done_next  = 1'b1;
            end else begin
              a_next     = req.day_count + EPOCH_DAYS;
              c_next     = req.day_count + EPOCH_DAYS;
              k_next     = WDAY_TOP;
              state_next = ST_WDAY;
            end
          end else begin
            if ((req.month inside {[4'd1:4'd12]}) &&
                (req.year inside {[YEAR_MIN:YEAR_MAX]})) begin
              a_next     = CW'(req.year - 14'd1);
              c_next     = EPOCH_NEG;
              k_next     = Y400_TOP;
              state_next = ST_Y400;
            end else begin
              rsp_q_next            = '0;
              rsp_q_next.date_error = 1'b1;
              done_next             = 1'b1;
            end
          end
        end
      end

      ST_WDAY: begin
        op_b   = WEEK << k;
        a_next = u_a;
        if (k == 5'd0) begin
          if (to_date) begin
            wd_next    = wday_fix(u_a[2:0], WD_OFS_DAYS);
            a_next     = c;
            c_next     = YRS_1;
            k_next     = Y400_TOP;
            state_next = ST_Y400;
          end else begin
            rsp_q_next.out_day_count = c;
            rsp_q_next.out_day       = req_q.day;
            rsp_q_next.out_month     = req_q.month;
            rsp_q_next.out_year      = req_q.year;
            rsp_q_next.weekday       = wday_fix(u_a[2:0], WD_OFS_EPOCH);
            rsp_q_next.valid_res     = 1'b1;
            rsp_q_next.date_error    = 1'b0;
            done_next                = 1'b1;
            state_next               = ST_IDLE;
          end
        end else begin
          k_next = k - 5'd1;
        end
      end

      ST_Y400: begin
        op_b   = to_date ? (DAYS_400 << k) : (YRS_400 << k);
        op_q   = to_date ? (YRS_400 << k) : (DAYS_400 << k);
        a_next = u_a;
        c_next = u_c;
        if (k == 5'd0) begin
          k_next     = Y100_TOP;
          state_next = ST_Y100;
        end else begin
          k_next = k - 5'd1;
        end
      end

      ST_Y100: begin
        op_b          = to_date ? (DAYS_100 << k) : (YRS_100 << k);
        op_q          = to_date ? (YRS_100 << k) : (DAYS_100 << k);
        a_next        = u_a;
        c_next        = u_c;
        n100_next[k[0]] = u_ge;
        if (k == 5'd0) begin
          k_next     = Y4_TOP;
          state_next = ST_Y4;
        end else begin
          k_next = k - 5'd1;
        end
      end

      ST_Y4: begin
        op_b            = to_date ? (DAYS_4 << k) : (YRS_4 << k);
        op_q            = to_date ? (YRS_4 << k) : (DAYS_4 << k);
        a_next          = u_a;
        c_next          = u_c;
        n4_next[k[2:0]] = u_ge;
        if (k == 5'd0) begin
          k_next     = Y1_TOP;
          state_next = ST_Y1;
        end else begin
          k_next = k - 5'd1;
        end
      end

      ST_Y1: begin
        op_b          = to_date ? (DAYS_1 << k) : (YRS_1 << k);
        op_q          = to_date ? (YRS_1 << k) : (DAYS_1 << k);
        a_next        = u_a;
        c_next        = u_c;
        n1_next[k[0]] = u_ge;
        if (k == 5'd0) begin
          mm_next    = 4'd1;
          state_next = to_date ? ST_MONTH : ST_DAYS;
        end else begin
          k_next = k - 5'd1;
        end
      end

      ST_MONTH: begin
        op_b = CW'(month_len(mm, leap));
        if ((mm == 4'd12) || !u_ge) begin
          rsp_q_next.out_day_count = req_q.day_count;
          rsp_q_next.out_day       = a[4:0] + 5'd1;
          rsp_q_next.out_month     = mm;
          rsp_q_next.out_year      = c[13:0];
          rsp_q_next.weekday       = wd;
          rsp_q_next.valid_res     = 1'b1;
          rsp_q_next.date_error    = 1'b0;
          done_next                = 1'b1;
          state_next               = ST_IDLE;
        end else begin
          a_next  = u_a;
          mm_next = mm + 4'd1;
        end
      end

      ST_DAYS: begin
        op_q = CW'(mo_off);
        if ((req_q.day == 5'd0) || (req_q.day > month_len(req_q.month, leap))) begin
          rsp_q_next            = '0;
          rsp_q_next.date_error = 1'b1;
          done_next             = 1'b1;
          state_next            = ST_IDLE;
        end else begin
          c_next     = u_c;
          a_next     = u_c;
          k_next     = WDAY_TOP;
          state_next = ST_WDAY;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k     <= k_next;
    a     <= a_next;
    c     <= c_next;
    n100  <= n100_next;
    n4    <= n4_next;
    n1    <= n1_next;
    wd    <= wd_next;
    mm    <= mm_next;
    req_q <= req_q_next;
    rsp_q <= rsp_q_next;
  end

  assign busy = (state != ST_IDLE);
  assign done = done_q;
  assign rsp  = rsp_q;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while sequencer still running");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
      done |-> !(rsp.valid_res && rsp.date_error))
    else $error("valid and error flags both set");

  a_date_sane: assert property (@(posedge clk) disable iff (rst)
      (done && rsp.valid_res) |->
      ((rsp.out_month != 4'd0) && (rsp.out_month <= 4'd12) &&
       (rsp.out_day != 5'd0) && (rsp.weekday <= 3'd6)))
    else $error("converted date out of range");

  a_start_progress: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither running nor finished");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
      (done && rsp.date_error) |-> (rsp.out_day_count == '0))
    else $error("error result carries a count");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import edc_pkg::*;

  localparam int MAX_GAP      = 17;
  localparam int TAIL_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 1080;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  edc_req_t req   = '0;
  logic     busy;
  logic     done;
  edc_rsp_t rsp;

  edc_rsp_t expected_dates[$];
  int       fail_count = 0;
  bit       burst_mode = 1'b0;

  epoch_day_date_converter dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m == 2) begin
      return is_leap(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // days from 1970-01-01 to January 1 of year y
  function automatic int unsigned year_start(int unsigned y);
    int unsigned p;
    int unsigned q;
    p = y - 1;
    q = 32'(YEAR_MIN) - 32'd1;
    return (365 * p + p / 4 - p / 100 + p / 400) - (365 * q + q / 4 - q / 100 + q / 400);
  endfunction

  function automatic edc_rsp_t convert_date(edc_req_t r);
    edc_rsp_t    res;
    int unsigned cnt;
    int unsigned rem;
    int unsigned yy;
    int unsigned mm;
    int unsigned total;
    res = '0;
    if (r.action == ACT_TO_DATE) begin
      if (r.day_count <= LAST_INDEX) begin
        cnt = 32'(r.day_count);
        yy  = 32'(YEAR_MIN) + cnt / 366;
        while (year_start(yy + 1) <= cnt) yy++;
        rem = cnt - year_start(yy);
        mm  = 1;
        while (mm < 12 && rem >= month_days(mm, yy)) begin
          rem -= month_days(mm, yy);
          mm++;
        end
        res.out_day_count = 22'(cnt);
        res.out_day       = 5'(rem + 1);
        res.out_month     = 4'(mm);
        res.out_year      = 14'(yy);
        res.weekday       = 3'((cnt + 32'(WD_OFS_EPOCH)) % 7);
        res.valid_res     = 1'b1;
      end
    end else begin
      if (r.month >= 4'd1 && r.month <= 4'd12 && r.year >= YEAR_MIN && r.year <= YEAR_MAX &&
          r.day >= 5'd1 && 32'(r.day) <= month_days(32'(r.month), 32'(r.year))) begin
        total = year_start(32'(r.year));
        for (mm = 1; mm < 32'(r.month); mm++) begin
          total += month_days(mm, 32'(r.year));
        end
        total += 32'(r.day) - 32'd1;
        res.out_day_count = 22'(total);
        res.out_day       = r.day;
        res.out_month     = r.month;
        res.out_year      = r.year;
        res.weekday       = 3'((total + 32'(WD_OFS_EPOCH)) % 7);
        res.valid_res     = 1'b1;
      end else begin
        res.date_error = 1'b1;
      end
    end
    return res;
  endfunction

  // unused fields carry random filler
  function automatic edc_req_t count_req(logic [21:0] cnt);
    edc_req_t r;
    r = $bits(edc_req_t)'({$urandom, $urandom});
    r.action    = ACT_TO_DATE;
    r.day_count = cnt;
    return r;
  endfunction

  function automatic edc_req_t date_req(logic [4:0] d, logic [3:0] m, logic [13:0] y);
    edc_req_t r;
    r = $bits(edc_req_t)'({$urandom, $urandom});
    r.action = ACT_TO_COUNT;
    r.day    = d;
    r.month  = m;
    r.year   = y;
    return r;
  endfunction

  function automatic edc_req_t random_item();
    edc_req_t    r;
    int unsigned pick;
    r = $bits(edc_req_t)'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.action    = ACT_TO_DATE;
      r.day_count = 22'($urandom_range(0, 32'(LAST_INDEX)));
    end else if (pick < 48) begin
      r.action = ACT_TO_DATE;
    end else if (pick < 53) begin
      r.action    = ACT_TO_DATE;
      r.day_count = LAST_INDEX - 22'd3 + 22'($urandom_range(0, 6));
    end else if (pick < 88) begin
      r.action = ACT_TO_COUNT;
      r.year   = 14'($urandom_range(32'(YEAR_MIN), 32'(YEAR_MAX)));
      r.month  = 4'($urandom_range(1, 12));
      r.day    = 5'($urandom_range(1, month_days(32'(r.month), 32'(r.year))));
    end else if (pick < 93) begin
      r.action = ACT_TO_COUNT;
    end else begin
      // near-miss dates: day off by one, year range one wider at each end
      r.action = ACT_TO_COUNT;
      r.year   = 14'($urandom_range(32'(YEAR_MIN) - 32'd1, 32'(YEAR_MAX) + 32'd1));
      r.month  = 4'($urandom_range(1, 12));
      r.day    = ($urandom_range(0, 1) != 0) ? 5'd0 :
                 5'(month_days(32'(r.month), 32'(r.year)) + 32'd1);
    end
    return r;
  endfunction

  task automatic send_item(edc_req_t item);
    int gap;
    gap = burst_mode ? 0 : int'($urandom_range(0, MAX_GAP));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_dates.push_back(convert_date(item));
  endtask

  task automatic wait_results();
    start <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    edc_rsp_t want;
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: unexpected transaction %p", $time, rsp);
        end
      end else begin
        want = expected_dates.pop_front();
        check_field("out_day_count", 32'(want.out_day_count), 32'(rsp.out_day_count));
        check_field("out_day", 32'(want.out_day), 32'(rsp.out_day));
        check_field("out_month", 32'(want.out_month), 32'(rsp.out_month));
        check_field("out_year", 32'(want.out_year), 32'(rsp.out_year));
        check_field("weekday", 32'(want.weekday), 32'(rsp.weekday));
        check_field("valid_res", 32'(want.valid_res), 32'(rsp.valid_res));
        check_field("date_error", 32'(want.date_error), 32'(rsp.date_error));
      end
    end
  end

  task automatic test_count_limits();
    send_item(count_req(22'd0));
    send_item(count_req(22'd1));
    send_item(count_req(22'd59));       // 1970-03-01
    send_item(count_req(22'd10957));    // 2000-01-01
    send_item(count_req(22'd11016));    // leap day 2000
    send_item(count_req(22'h2AAAAA));
    send_item(count_req(LAST_INDEX - 22'd1));
    send_item(count_req(LAST_INDEX));
    send_item(count_req(LAST_INDEX + 22'd1));
    send_item(count_req(22'h3FFFFF));
  endtask

  task automatic test_date_checks();
    send_item(date_req(5'd1, 4'd1, 14'd1970));
    send_item(date_req(5'd31, 4'd12, 14'd9999));
    send_item(date_req(5'd31, 4'd1, 14'd9999));
    send_item(date_req(5'd29, 4'd2, 14'd2000));
    send_item(date_req(5'd29, 4'd2, 14'd2100));  // century, not leap
    send_item(date_req(5'd29, 4'd2, 14'd2400));
    send_item(date_req(5'd29, 4'd2, 14'd1971));
    send_item(date_req(5'd30, 4'd4, 14'd2023));
    send_item(date_req(5'd31, 4'd4, 14'd2023));
    send_item(date_req(5'd0, 4'd1, 14'd2000));
    send_item(date_req(5'd1, 4'd0, 14'd2000));
    send_item(date_req(5'd1, 4'd13, 14'd2000));
    send_item(date_req(5'd31, 4'd15, 14'd16383));
    send_item(date_req(5'd1, 4'd1, 14'd1969));
    send_item(date_req(5'd1, 4'd1, 14'd10000));
    send_item(date_req(5'd0, 4'd0, 14'd0));
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      send_item(random_item());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_count_limits();
    test_date_checks();
    wait_results();
    test_random_traffic(RANDOM_ITEMS / 2);
    wait_results();
    test_random_traffic(RANDOM_ITEMS / 2);
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
